// File: rtl/ede_pkg.sv
// Package for the edit distance engine: item and result types, command codes
// and the control word that travels along the cell chain. No dependencies.
`default_nettype none

package ede_pkg;

  // Command codes of an input item
  localparam logic CMD_A = 1'b0;
  localparam logic CMD_B = 1'b1;

  // Input item and result item
  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [10:0] distance;
    logic        overflow;
  } result_t;

  // Kind of token moving down the chain
  typedef enum logic [1:0] {
    TOK_A     = 2'b00,  // character of string A, parks in the first free cell
    TOK_B     = 2'b01,  // character of string B, updates one row as it passes
    TOK_FLUSH = 2'b10   // dropped last B character, collects the stored distance
  } tok_kind_t;

  // Control word of a token, handed from cell to cell
  typedef struct packed {
    logic      valid;
    tok_kind_t kind;
    logic [7:0] ch;
    logic      first;  // first B character of a pair: cells take their start value
    logic      last;   // final B character: emit result and free the cells
    logic      ovf;    // overflow seen for this pair, rides along to the result
  } tok_ctl_t;

endpackage

`default_nettype wire

// File: rtl/ede_cell.sv
// One cell of the edit distance chain: holds one character of string A and
// one entry of the distance row. Depends on ede_pkg.
`default_nettype none

module ede_cell #(
  parameter int DW  = 11,
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire ede_pkg::tok_ctl_t ctl_prev,
  input  wire logic [DW-1:0]    diag_prev,
  input  wire logic [DW-1:0]    left_prev,
  output ede_pkg::tok_ctl_t     ctl,
  output logic [DW-1:0]         diag,
  output logic [DW-1:0]         left
);

  logic          loaded;
  logic [7:0]    a_ch;
  logic [DW-1:0] up;

  logic              park;
  logic [DW-1:0]     up_eff;
  logic [DW-1:0]     sub_cost;
  logic [DW-1:0]     del_cost;
  logic [DW-1:0]     ins_cost;
  logic [DW-1:0]     min_a;
  logic [DW-1:0]     v;
  ede_pkg::tok_ctl_t ctl_next;
  logic [DW-1:0]     diag_next;
  logic [DW-1:0]     left_next;

  // Evaluate the row recurrence for the passing B character
  always_comb begin
    up_eff   = ctl_prev.first ? DW'(IDX + 1) : up;
    sub_cost = diag_prev + DW'(a_ch != ctl_prev.ch);
    del_cost = up_eff + DW'(1);
    ins_cost = left_prev + DW'(1);
    min_a    = (sub_cost < del_cost) ? sub_cost : del_cost;
    v        = (min_a < ins_cost) ? min_a : ins_cost;
  end

  // Park a free A character here, pass everything else on
  always_comb begin
    park           = ctl_prev.valid && (ctl_prev.kind == ede_pkg::TOK_A) && !loaded;
    ctl_next       = ctl_prev;
    ctl_next.valid = ctl_prev.valid && !park;
    diag_next      = diag_prev;
    left_next      = left_prev;
    if (ctl_prev.valid && loaded) begin
      case (ctl_prev.kind)
        ede_pkg::TOK_B: begin
          diag_next = up_eff;
          left_next = v;
        end
        ede_pkg::TOK_FLUSH: begin
          left_next = up;
        end
        default: ;
      endcase
    end
  end

  // Track occupancy and hand the control word on
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      ctl    <= '0;
    end else if (advance) begin
      ctl <= ctl_next;
      if (ctl_prev.valid) begin
        case (ctl_prev.kind)
          ede_pkg::TOK_A: begin
            if (!loaded) begin
              loaded <= 1'b1;
            end
          end
          ede_pkg::TOK_B: begin
            if (loaded && ctl_prev.last) begin
              loaded <= 1'b0;
            end
          end
          ede_pkg::TOK_FLUSH: begin
            loaded <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Store the character and row entry, pass distances to the neighbor
  always_ff @(posedge clk) begin
    if (advance) begin
      diag <= diag_next;
      left <= left_next;
      if (ctl_prev.valid) begin
        case (ctl_prev.kind)
          ede_pkg::TOK_A: begin
            if (!loaded) begin
              a_ch <= ctl_prev.ch;
            end
          end
          ede_pkg::TOK_B: begin
            if (loaded) begin
              up <= v;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/edit_distance_engine_top.sv
// Edit distance engine top level: input bookkeeping, chain of ede_cell
// instances and the result register. Depends on ede_pkg and ede_cell.
//
// Computes the Levenshtein distance (unit cost insert, delete, substitute)
// between string A and string B. Send A characters (cmd 0), then B characters
// (cmd 1); the B character flagged last closes the pair and yields one
// result. Unless stalled, the block takes one item per cycle, A and B alike.
// Each accepted character becomes a token in a chain of MAX_LEN cells, moving
// one cell per cycle: A characters park in the first free cell, B characters
// sweep the chain as a wavefront and update one row entry in each cell. The
// result of a pair is registered once its last B character reaches the end of
// the chain; the next pair may follow right behind it. The chain, and with it
// the input, stalls only while a finished result waits and another one
// reaches the end of the chain. Characters beyond MAX_LEN in either string are
// dropped and set overflow. No clearing pass is needed after reset.
`default_nettype none

module edit_distance_engine_top #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire ede_pkg::item_t item,
  output logic                result_valid,
  input  wire logic           result_stall,
  output ede_pkg::result_t    result
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int DW = $clog2(MAX_LEN + 2);

  logic [CW-1:0] a_length, a_length_next;
  logic [CW-1:0] b_count, b_count_next;
  logic          in_b_phase, in_b_phase_next;
  logic          overflow_seen, overflow_seen_next;

  ede_pkg::tok_ctl_t ctl_chain  [0:MAX_LEN];
  logic [DW-1:0]     diag_chain [0:MAX_LEN];
  logic [DW-1:0]     left_chain [0:MAX_LEN];

  ede_pkg::tok_ctl_t head_ctl;
  logic [DW-1:0]     head_diag;
  logic [DW-1:0]     head_left;

  logic        advance;
  logic        accept;
  logic        end_last;
  logic [31:0] dist_wide;

  // Hold the chain while a result waits and another one arrives
  assign end_last   = ctl_chain[MAX_LEN].valid && ctl_chain[MAX_LEN].last;
  assign advance    = !(end_last && result_valid && result_stall);
  assign item_stall = !advance;
  assign accept     = item_valid && advance;

  // Build the token for the accepted item and advance the pair state
  always_comb begin
    head_ctl           = '0;
    head_ctl.kind      = ede_pkg::TOK_A;
    head_ctl.ch        = item.ch;
    head_diag          = DW'(b_count);
    head_left          = DW'(b_count) + DW'(1);
    a_length_next      = a_length;
    b_count_next       = b_count;
    in_b_phase_next    = in_b_phase;
    overflow_seen_next = overflow_seen;
    if (accept) begin
      case (item.cmd)
        ede_pkg::CMD_A: begin
          if (!in_b_phase) begin
            if (a_length < CW'(MAX_LEN)) begin
              head_ctl.valid = 1'b1;
              a_length_next  = a_length + CW'(1);
            end else begin
              overflow_seen_next = 1'b1;
            end
          end
        end
        ede_pkg::CMD_B: begin
          in_b_phase_next = 1'b1;
          if (b_count < CW'(MAX_LEN)) begin
            head_ctl.valid = 1'b1;
            head_ctl.kind  = ede_pkg::TOK_B;
            head_ctl.first = !in_b_phase;
            head_ctl.last  = item.last;
            head_ctl.ovf   = overflow_seen;
            b_count_next   = b_count + CW'(1);
          end else begin
            overflow_seen_next = 1'b1;
            if (item.last) begin
              head_ctl.valid = 1'b1;
              head_ctl.kind  = ede_pkg::TOK_FLUSH;
              head_ctl.last  = 1'b1;
              head_ctl.ovf   = 1'b1;
              head_left      = DW'(b_count);
            end
          end
          // Close the pair
          if (item.last) begin
            a_length_next      = '0;
            b_count_next       = '0;
            in_b_phase_next    = 1'b0;
            overflow_seen_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Feed the token into the head of the chain
  assign ctl_chain[0]  = head_ctl;
  assign diag_chain[0] = head_diag;
  assign left_chain[0] = head_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_length      <= '0;
      b_count       <= '0;
      in_b_phase    <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      a_length      <= a_length_next;
      b_count       <= b_count_next;
      in_b_phase    <= in_b_phase_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Chain of cells, one per position of string A
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    ede_cell #(
      .DW  (DW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .ctl_prev  (ctl_chain[i]),
      .diag_prev (diag_chain[i]),
      .left_prev (left_chain[i]),
      .ctl       (ctl_chain[i+1]),
      .diag      (diag_chain[i+1]),
      .left      (left_chain[i+1])
    );
  end

  assign dist_wide = 32'(left_chain[MAX_LEN]);

  // Capture the finished distance, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && end_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && end_last) begin
      result.distance <= dist_wide[10:0];
      result.overflow <= ctl_chain[MAX_LEN].ovf;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/edit_distance_checker.sv
// Checker for the edit distance engine: watches both channels, predicts each
// pair's distance and compares it with the block's results.
// Depends on ede_pkg for the item and result types and the command codes.
module edit_distance_checker #(
  parameter int MAX_LEN = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  ede_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  ede_pkg::result_t result,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted pair state
  logic [7:0]  a_text [MAX_LEN];
  logic [10:0] cost_row [MAX_LEN];
  int          a_count;
  int          b_seen;
  logic        b_active;
  logic        truncated;

  // Distances predicted but not yet seen on the result channel
  ede_pkg::result_t distance_q [$];
  ede_pkg::result_t want;

  // Fold one accepted item into the pair state; queue a distance on last B
  task automatic take_char(input ede_pkg::item_t it);
    int i;
    int diag;
    int left;
    int up;
    int v;
    ede_pkg::result_t r;
    if (it.cmd == ede_pkg::CMD_A) begin
      // Drop A characters once B has started; flag the ones past the limit
      if (!b_active) begin
        if (a_count < MAX_LEN) begin
          a_text[a_count] = it.ch;
          a_count++;
        end else begin
          truncated = 1'b1;
        end
      end
    end else begin
      // First B character seeds the row with the distances to empty B
      if (!b_active) begin
        b_active = 1'b1;
        for (i = 0; i < a_count; i++) cost_row[i] = 11'(i + 1);
      end
      if (b_seen < MAX_LEN) begin
        diag = b_seen;
        left = b_seen + 1;
        for (i = 0; i < a_count; i++) begin
          up = int'(cost_row[i]);
          v = diag + ((a_text[i] != it.ch) ? 1 : 0);
          if (up + 1 < v) v = up + 1;
          if (left + 1 < v) v = left + 1;
          diag = up;
          cost_row[i] = 11'(v);
          left = v;
        end
        b_seen++;
      end else begin
        truncated = 1'b1;
      end
      // Close the pair and clear for the next one
      if (it.last) begin
        r.distance = (a_count == 0) ? 11'(b_seen) : cost_row[a_count - 1];
        r.overflow = truncated;
        distance_q.push_back(r);
        a_count = 0;
        b_seen = 0;
        b_active = 1'b0;
        truncated = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      a_count = 0;
      b_seen = 0;
      b_active = 1'b0;
      truncated = 1'b0;
      errors = 0;
      distance_q.delete();
    end else begin
      // Compare an accepted result with the oldest predicted distance
      if (result_valid && !result_stall) begin
        if (distance_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: distance %0d overflow %0b",
                   $time, result.distance, result.overflow);
        end else begin
          want = distance_q.pop_front();
          if (want.distance !== result.distance) begin
            errors++;
            $display("%0t: distance mismatch: expected %0d actual %0d",
                     $time, want.distance, result.distance);
          end
          if (want.overflow !== result.overflow) begin
            errors++;
            $display("%0t: overflow mismatch: expected %0b actual %0b",
                     $time, want.overflow, result.overflow);
          end
        end
      end
      if (item_valid && !item_stall) take_char(item);
    end
    pending = distance_q.size();
  end

endmodule

// File: tb/sv/tb_edit_distance_engine_top.sv
// Testbench top for edit_distance_engine_top: drives character items with
// random gaps and result stalls, and gives the verdict from the checker.
// Depends on ede_pkg, the engine RTL and edit_distance_checker.
module tb_edit_distance_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN    = 1024;
  localparam int RAND_ITEMS = 950;
  localparam int LIMIT      = 500000;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  ede_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  ede_pkg::result_t result;
  int               errors;
  int               pending;
  int               cycle_count = 0;

  // Sender idling: stretches of random gaps alternate with gap-free ones
  int      send_left = 0;
  logic    send_quiet = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  edit_distance_engine_top #(.MAX_LEN(MAX_LEN)) uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  edit_distance_checker #(.MAX_LEN(MAX_LEN)) chk (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .errors      (errors),
    .pending     (pending)
  );

  // Send one character item; called and returning at a falling edge
  task automatic send_char(input logic c, input logic [7:0] b, input logic l);
    int gap;
    if (send_left == 0) begin
      send_left = $urandom_range(10, 60);
      send_quiet = ($urandom_range(0, 3) == 0);
    end
    send_left--;
    gap = send_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    item = '{cmd: c, ch: b, last: l};
    // Hold the item until the block takes it
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Main stimulus
  initial begin
    int       k;
    int       j;
    int       na;
    int       nb;
    int       n_sent;
    logic     wide;
    logic [7:0] c;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty A: distance is the B length
    send_char(ede_pkg::CMD_B, 8'h00, 1'b1);
    // Last flag on an A character has no effect; extreme byte values
    send_char(ede_pkg::CMD_A, 8'h00, 1'b1);
    send_char(ede_pkg::CMD_A, 8'hFF, 1'b0);
    send_char(ede_pkg::CMD_B, 8'hFF, 1'b0);
    send_char(ede_pkg::CMD_B, 8'h00, 1'b1);
    // A character during the B phase is ignored
    send_char(ede_pkg::CMD_A, 8'h41, 1'b0);
    send_char(ede_pkg::CMD_B, 8'h41, 1'b0);
    send_char(ede_pkg::CMD_A, 8'h42, 1'b1);
    send_char(ede_pkg::CMD_B, 8'h43, 1'b1);
    // Identical strings
    send_char(ede_pkg::CMD_A, 8'h80, 1'b0);
    send_char(ede_pkg::CMD_A, 8'h7F, 1'b0);
    send_char(ede_pkg::CMD_B, 8'h80, 1'b0);
    send_char(ede_pkg::CMD_B, 8'h7F, 1'b1);
    // Delete at the front, insert at the back
    send_char(ede_pkg::CMD_A, 8'h01, 1'b0);
    send_char(ede_pkg::CMD_A, 8'h02, 1'b0);
    send_char(ede_pkg::CMD_A, 8'h03, 1'b0);
    send_char(ede_pkg::CMD_B, 8'h02, 1'b0);
    send_char(ede_pkg::CMD_B, 8'h03, 1'b0);
    send_char(ede_pkg::CMD_B, 8'h04, 1'b1);

    // A past the limit: distance reaches its ceiling and overflow is set
    for (k = 0; k < MAX_LEN + 2; k++)
      send_char(ede_pkg::CMD_A, 8'h55, k == MAX_LEN + 1);
    send_char(ede_pkg::CMD_B, 8'hAA, 1'b1);
    // B past the limit, final dropped B carries last
    for (k = 0; k < 3; k++)
      send_char(ede_pkg::CMD_A, 8'(8'h61 + $urandom_range(0, 3)), 1'b0);
    for (k = 0; k < MAX_LEN + 2; k++)
      send_char(ede_pkg::CMD_B, 8'(8'h61 + $urandom_range(0, 3)), k == MAX_LEN + 1);

    // Random pairs, mostly over a small alphabet so characters match often
    n_sent = 0;
    while (n_sent < RAND_ITEMS) begin
      na = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
      nb = $urandom_range(1, 20);
      wide = ($urandom_range(0, 3) == 0);
      for (k = 0; k < na; k++) begin
        c = wide ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 3));
        send_char(ede_pkg::CMD_A, c, $urandom_range(0, 7) == 0);
      end
      for (j = 0; j < nb; j++) begin
        // Sprinkle stray A characters into the B phase
        if ($urandom_range(0, 9) == 0)
          send_char(ede_pkg::CMD_A, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        c = wide ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 3));
        send_char(ede_pkg::CMD_B, c, j == nb - 1);
      end
      n_sent += na + nb;
    end
    item_valid = 1'b0;

    // Drain the pipeline, then let it settle for its latency
    while (pending != 0) @(negedge clk);
    repeat (MAX_LEN + 32) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_edit_distance_engine_top: PASS");
    end else begin
      $display("tb_edit_distance_engine_top: FAIL");
    end
    $finish;
  end

  // Result side: before each result, stall for a random number of cycles or, in quiet stretches, not at all
  initial begin
    int   hold;
    int   stall_left;
    logic stall_quiet;
    stall_left = 0;
    stall_quiet = 1'b0;
    result_stall = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(5, 40);
        stall_quiet = ($urandom_range(0, 3) == 0);
      end
      stall_left--;
      hold = stall_quiet ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        result_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_edit_distance_engine_top: FAIL");
      $finish;
    end
  end

endmodule
